// ===== design/htok_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htok_pkg
// Types, codes and character tables shared by the request tokenizer.
// ----------------------------------------------------------------------------
package htok_pkg;

  typedef enum logic [3:0] {
    PH_METHOD = 4'd0,
    PH_SP1    = 4'd1,
    PH_URI    = 4'd2,
    PH_SP2    = 4'd3,
    PH_VHTTP  = 4'd4,
    PH_VREST  = 4'd5,
    PH_VLF    = 4'd6,
    PH_LINE   = 4'd7,
    PH_NAME   = 4'd8,
    PH_VALUE  = 4'd9,
    PH_VALLF  = 4'd10,
    PH_ENDLF  = 4'd11,
    PH_BODY   = 4'd12,
    PH_ERR    = 4'd13
  } phase_e;

  typedef enum logic [2:0] {
    K_METHOD  = 3'd0,
    K_URI     = 3'd1,
    K_VERSION = 3'd2,
    K_NAME    = 3'd3,
    K_VALUE   = 3'd4,
    K_BODY    = 3'd5,
    K_ERROR   = 3'd6
  } kind_e;

  typedef enum logic [2:0] {
    C_NONE    = 3'd0,
    C_METHOD  = 3'd1,
    C_SLASH   = 3'd2,
    C_VERSION = 3'd3,
    C_LF      = 3'd4,
    C_EARLY   = 3'd5,
    C_HEADERS = 3'd6,
    C_LENGTH  = 3'd7
  } cause_e;

  localparam logic [1:0] M_GET  = 2'd0;
  localparam logic [1:0] M_POST = 2'd1;
  localparam logic [1:0] M_HEAD = 2'd2;
  localparam logic [1:0] M_PUT  = 2'd3;

  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_U     = 8'h55;

  localparam int unsigned START_MAX = 2047;

  typedef struct packed {
    cause_e      cause;
    logic [3:0]  hidx;
    logic [1:0]  method;
    logic [11:0] length;
    logic [10:0] start;
    kind_e       kind;
  } token_t;

  function automatic logic [7:0] meth_char(input logic [1:0] m, input logic [1:0] idx);
    logic [7:0] c;
    c = 8'h00;
    case (m)
      M_GET: begin
        case (idx)
          2'd0:    c = 8'h47;
          2'd1:    c = 8'h45;
          2'd2:    c = 8'h54;
          default: c = 8'h00;
        endcase
      end
      M_POST: begin
        case (idx)
          2'd0:    c = 8'h50;
          2'd1:    c = 8'h4F;
          2'd2:    c = 8'h53;
          default: c = 8'h54;
        endcase
      end
      M_HEAD: begin
        case (idx)
          2'd0:    c = 8'h48;
          2'd1:    c = 8'h45;
          2'd2:    c = 8'h41;
          default: c = 8'h44;
        endcase
      end
      default: begin
        case (idx)
          2'd0:    c = 8'h50;
          2'd1:    c = 8'h55;
          2'd2:    c = 8'h54;
          default: c = 8'h00;
        endcase
      end
    endcase
    return c;
  endfunction

  function automatic logic [2:0] meth_len(input logic [1:0] m);
    logic [2:0] n;
    case (m)
      M_POST, M_HEAD: n = 3'd4;
      default:        n = 3'd3;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] http_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = 8'h48;
      2'd1:    c = 8'h54;
      2'd2:    c = 8'h54;
      default: c = 8'h50;
    endcase
    return c;
  endfunction

endpackage

// ===== design/http_request_tokenizer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_request_tokenizer
// Streaming tokenizer for request text: one byte per transaction in, one
// token record out at each token end.
// ----------------------------------------------------------------------------
//  channel   dir  tdata                                      tuser       tlast
//  s_axis    in   [7:0] data_byte                            -           end_of_request
//  m_axis    out  start, length, method, header idx, cause   token_kind  -
//
//  One byte per cycle while the output queue has room: a byte waits in the input
//  register, then the parser updates its state and writes at most one record to a
//  two-entry output queue, which offers it in the cycle after the parser step.
//  Reset clears the parser to the start of a request and empties the queue.
//  An output stall holds the queue; the input stalls only once it is full.
// ----------------------------------------------------------------------------
module http_request_tokenizer #(
  parameter int unsigned BUF_BYTES   = 2048,
  parameter int unsigned MAX_HEADERS = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [10:0] token_start, [22:11] token_length,
                                      // [24:23] method_code, [28:25] header_index,
                                      // [31:29] error_cause
  output logic [2:0]  m_axis_tuser    // [2:0] token_kind
);

  logic             in_vld_q;
  logic [7:0]       in_data_q;
  logic             in_last_q;
  logic             adv;
  logic             room;
  logic             res_vld;
  htok_pkg::token_t res;
  htok_pkg::token_t out_tok;

  assign adv           = in_vld_q && room;
  assign s_axis_tready = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_data_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  htok_parse #(
    .BUF_BYTES   (BUF_BYTES),
    .MAX_HEADERS (MAX_HEADERS)
  ) u_parse (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (adv),
    .byte_i    (in_data_q),
    .last_i    (in_last_q),
    .tok_vld_o (res_vld),
    .tok_o     (res)
  );

  htok_obuf u_obuf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_vld),
    .tok_i  (res),
    .room_o (room),
    .vld_o  (m_axis_tvalid),
    .rdy_i  (m_axis_tready),
    .tok_o  (out_tok)
  );

  assign m_axis_tuser = out_tok.kind;
  assign m_axis_tdata = {out_tok.cause, out_tok.hidx, out_tok.method,
                         out_tok.length, out_tok.start};

  a_res_on_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld |-> adv)
    else $error("record produced without a parser step");

  a_full_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !room |-> m_axis_tvalid)
    else $error("result queue full but nothing offered");

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !adv |=> in_vld_q && $stable(in_data_q) && $stable(in_last_q))
    else $error("input register lost a stalled byte");

  a_err_rec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld && res.kind == htok_pkg::K_ERROR |->
      res.length == 12'd0 && res.method == 2'd0 && res.cause != htok_pkg::C_NONE)
    else $error("malformed error record");

endmodule

// ===== design/htok_parse.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htok_parse
// Parser state and the per-byte next-state logic; one token record per step
// at most.
// ----------------------------------------------------------------------------
module htok_parse #(
  parameter int unsigned BUF_BYTES   = 2048,
  parameter int unsigned MAX_HEADERS = 10
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        byte_i,
  input  logic              last_i,
  output logic              tok_vld_o,
  output htok_pkg::token_t  tok_o
);

  localparam int unsigned PW = $clog2(BUF_BYTES + 1);
  localparam int unsigned HW = $clog2(MAX_HEADERS + 1);

  htok_pkg::phase_e phase_q, phase_d, eff;
  logic [PW-1:0]    pos_q, pos_d;
  logic [PW-1:0]    tstart_q, tstart_d;
  logic [PW-1:0]    tlen_q, tlen_d;
  logic [1:0]       cand_q, cand_d, cand_eff;
  logic [2:0]       mc_q, mc_d, mc_inc;
  logic [HW-1:0]    hc_q, hc_d;
  logic [1:0]       found_q, found_d;
  logic             swallow;

  logic                 emit;
  htok_pkg::kind_e      rec_kind;
  htok_pkg::cause_e     rec_cause;
  logic [PW-1:0]        rec_start;
  logic [PW-1:0]        rec_len;
  logic [HW-1:0]        rec_hidx;
  logic [1:0]           rec_method;
  logic [31:0]          start_ext, len_ext, hidx_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= htok_pkg::PH_METHOD;
      pos_q    <= '0;
      tstart_q <= '0;
      tlen_q   <= '0;
      cand_q   <= '0;
      mc_q     <= '0;
      hc_q     <= '0;
      found_q  <= '0;
    end else begin
      phase_q  <= phase_d;
      pos_q    <= pos_d;
      tstart_q <= tstart_d;
      tlen_q   <= tlen_d;
      cand_q   <= cand_d;
      mc_q     <= mc_d;
      hc_q     <= hc_d;
      found_q  <= found_d;
    end
  end

  always_comb begin
    phase_d    = phase_q;
    pos_d      = pos_q;
    tstart_d   = tstart_q;
    tlen_d     = tlen_q;
    cand_d     = cand_q;
    mc_d       = mc_q;
    hc_d       = hc_q;
    found_d    = found_q;
    eff        = phase_q;
    swallow    = 1'b0;
    emit       = 1'b0;
    rec_kind   = htok_pkg::K_METHOD;
    rec_cause  = htok_pkg::C_NONE;
    rec_start  = '0;
    rec_len    = '0;
    rec_hidx   = '0;
    rec_method = found_q;
    mc_inc     = mc_q + 3'd1;
    cand_eff   = cand_q;
    if (cand_q == htok_pkg::M_POST && mc_q == 3'd1 && byte_i == htok_pkg::CH_U) begin
      cand_eff = htok_pkg::M_PUT;
    end

    if (step_i) begin
      if (phase_q == htok_pkg::PH_ERR) begin
        if (last_i) begin
          phase_d  = htok_pkg::PH_METHOD;
          pos_d    = '0;
          tstart_d = '0;
          tlen_d   = '0;
          cand_d   = '0;
          mc_d     = '0;
          hc_d     = '0;
          found_d  = '0;
        end
      end else begin
        if (pos_q >= PW'(BUF_BYTES)) begin
          phase_d    = htok_pkg::PH_ERR;
          emit       = 1'b1;
          rec_kind   = htok_pkg::K_ERROR;
          rec_start  = pos_q;
          rec_method = '0;
          rec_cause  = htok_pkg::C_LENGTH;
        end else begin
          if (phase_q == htok_pkg::PH_VALLF) begin
            phase_d = htok_pkg::PH_LINE;
            eff     = htok_pkg::PH_LINE;
            swallow = (byte_i == htok_pkg::CH_LF);
          end
          if (!swallow) begin
            case (eff)
              htok_pkg::PH_METHOD: begin
                if (mc_q == 3'd0) begin
                  mc_d = 3'd1;
                  if (byte_i == htok_pkg::CH_G) begin
                    cand_d = htok_pkg::M_GET;
                  end else if (byte_i == htok_pkg::CH_P) begin
                    cand_d = htok_pkg::M_POST;
                  end else if (byte_i == htok_pkg::CH_H) begin
                    cand_d = htok_pkg::M_HEAD;
                  end else begin
                    phase_d    = htok_pkg::PH_ERR;
                    emit       = 1'b1;
                    rec_kind   = htok_pkg::K_ERROR;
                    rec_start  = pos_q;
                    rec_method = '0;
                    rec_cause  = htok_pkg::C_METHOD;
                  end
                end else begin
                  cand_d = cand_eff;
                  if (byte_i != htok_pkg::meth_char(cand_eff, mc_q[1:0])) begin
                    phase_d    = htok_pkg::PH_ERR;
                    emit       = 1'b1;
                    rec_kind   = htok_pkg::K_ERROR;
                    rec_start  = pos_q;
                    rec_method = '0;
                    rec_cause  = htok_pkg::C_METHOD;
                  end else if (mc_inc >= htok_pkg::meth_len(cand_eff)) begin
                    found_d    = cand_eff;
                    mc_d       = '0;
                    phase_d    = htok_pkg::PH_SP1;
                    emit       = 1'b1;
                    rec_kind   = htok_pkg::K_METHOD;
                    rec_len    = PW'(htok_pkg::meth_len(cand_eff));
                    rec_method = cand_eff;
                  end else begin
                    mc_d = mc_inc;
                  end
                end
              end
              htok_pkg::PH_SP1: begin
                if (byte_i == htok_pkg::CH_SP) begin
                  phase_d = phase_q;
                end else if (byte_i != htok_pkg::CH_SLASH) begin
                  phase_d    = htok_pkg::PH_ERR;
                  emit       = 1'b1;
                  rec_kind   = htok_pkg::K_ERROR;
                  rec_start  = pos_q;
                  rec_method = '0;
                  rec_cause  = htok_pkg::C_SLASH;
                end else begin
                  tstart_d = pos_q;
                  tlen_d   = PW'(1);
                  phase_d  = htok_pkg::PH_URI;
                end
              end
              htok_pkg::PH_URI: begin
                if (byte_i == htok_pkg::CH_SP) begin
                  phase_d   = htok_pkg::PH_SP2;
                  emit      = 1'b1;
                  rec_kind  = htok_pkg::K_URI;
                  rec_start = tstart_q;
                  rec_len   = tlen_q;
                end else begin
                  tlen_d = tlen_q + PW'(1);
                end
              end
              htok_pkg::PH_SP2: begin
                if (byte_i == htok_pkg::CH_SP) begin
                  phase_d = phase_q;
                end else if (byte_i != htok_pkg::CH_H) begin
                  phase_d    = htok_pkg::PH_ERR;
                  emit       = 1'b1;
                  rec_kind   = htok_pkg::K_ERROR;
                  rec_start  = pos_q;
                  rec_method = '0;
                  rec_cause  = htok_pkg::C_VERSION;
                end else begin
                  tstart_d = pos_q;
                  tlen_d   = PW'(1);
                  mc_d     = 3'd1;
                  phase_d  = htok_pkg::PH_VHTTP;
                end
              end
              htok_pkg::PH_VHTTP: begin
                if (byte_i != htok_pkg::http_char(mc_q[1:0])) begin
                  phase_d    = htok_pkg::PH_ERR;
                  emit       = 1'b1;
                  rec_kind   = htok_pkg::K_ERROR;
                  rec_start  = pos_q;
                  rec_method = '0;
                  rec_cause  = htok_pkg::C_VERSION;
                end else begin
                  tlen_d = tlen_q + PW'(1);
                  if (mc_inc >= 3'd4) begin
                    mc_d    = '0;
                    phase_d = htok_pkg::PH_VREST;
                  end else begin
                    mc_d = mc_inc;
                  end
                end
              end
              htok_pkg::PH_VREST: begin
                if (byte_i == htok_pkg::CH_CR) begin
                  phase_d = htok_pkg::PH_VLF;
                end else begin
                  tlen_d = tlen_q + PW'(1);
                end
              end
              htok_pkg::PH_VLF: begin
                if (byte_i != htok_pkg::CH_LF) begin
                  phase_d    = htok_pkg::PH_ERR;
                  emit       = 1'b1;
                  rec_kind   = htok_pkg::K_ERROR;
                  rec_start  = pos_q;
                  rec_method = '0;
                  rec_cause  = htok_pkg::C_LF;
                end else begin
                  phase_d   = htok_pkg::PH_LINE;
                  emit      = 1'b1;
                  rec_kind  = htok_pkg::K_VERSION;
                  rec_start = tstart_q;
                  rec_len   = tlen_q;
                end
              end
              htok_pkg::PH_LINE: begin
                if (byte_i == htok_pkg::CH_CR) begin
                  phase_d = htok_pkg::PH_ENDLF;
                end else if (hc_q >= HW'(MAX_HEADERS)) begin
                  phase_d    = htok_pkg::PH_ERR;
                  emit       = 1'b1;
                  rec_kind   = htok_pkg::K_ERROR;
                  rec_start  = pos_q;
                  rec_method = '0;
                  rec_cause  = htok_pkg::C_HEADERS;
                end else if (byte_i == htok_pkg::CH_COLON) begin
                  phase_d   = htok_pkg::PH_VALUE;
                  tstart_d  = pos_q + PW'(1);
                  tlen_d    = '0;
                  emit      = 1'b1;
                  rec_kind  = htok_pkg::K_NAME;
                  rec_start = pos_q;
                  rec_hidx  = hc_q;
                end else begin
                  tstart_d = pos_q;
                  tlen_d   = PW'(1);
                  phase_d  = htok_pkg::PH_NAME;
                end
              end
              htok_pkg::PH_NAME: begin
                if (byte_i == htok_pkg::CH_COLON) begin
                  phase_d   = htok_pkg::PH_VALUE;
                  tstart_d  = pos_q + PW'(1);
                  tlen_d    = '0;
                  emit      = 1'b1;
                  rec_kind  = htok_pkg::K_NAME;
                  rec_start = tstart_q;
                  rec_len   = tlen_q;
                  rec_hidx  = hc_q;
                end else begin
                  tlen_d = tlen_q + PW'(1);
                end
              end
              htok_pkg::PH_VALUE: begin
                if (byte_i == htok_pkg::CH_CR) begin
                  hc_d      = hc_q + HW'(1);
                  phase_d   = htok_pkg::PH_VALLF;
                  emit      = 1'b1;
                  rec_kind  = htok_pkg::K_VALUE;
                  rec_start = tstart_q;
                  rec_len   = tlen_q;
                  rec_hidx  = hc_q;
                end else begin
                  tlen_d = tlen_q + PW'(1);
                end
              end
              htok_pkg::PH_ENDLF: begin
                if (byte_i != htok_pkg::CH_LF) begin
                  phase_d    = htok_pkg::PH_ERR;
                  emit       = 1'b1;
                  rec_kind   = htok_pkg::K_ERROR;
                  rec_start  = pos_q;
                  rec_method = '0;
                  rec_cause  = htok_pkg::C_LF;
                end else begin
                  phase_d  = htok_pkg::PH_BODY;
                  tstart_d = pos_q + PW'(1);
                  tlen_d   = '0;
                end
              end
              htok_pkg::PH_BODY: begin
                tlen_d = tlen_q + PW'(1);
              end
              default: begin
                phase_d = htok_pkg::PH_ERR;
              end
            endcase
          end
        end

        if (phase_d != htok_pkg::PH_ERR) begin
          pos_d = pos_q + PW'(1);
        end

        if (last_i) begin
          if (phase_d == htok_pkg::PH_ERR) begin
            rec_method = '0;
          end else if (!emit && phase_d == htok_pkg::PH_BODY) begin
            emit      = 1'b1;
            rec_kind  = htok_pkg::K_BODY;
            rec_start = tstart_d;
            rec_len   = tlen_d;
          end else if (!emit && phase_d == htok_pkg::PH_LINE) begin
            emit      = 1'b1;
            rec_kind  = htok_pkg::K_BODY;
            rec_start = pos_d;
            rec_len   = '0;
          end else begin
            emit       = 1'b1;
            rec_kind   = htok_pkg::K_ERROR;
            rec_start  = pos_q;
            rec_len    = '0;
            rec_hidx   = '0;
            rec_method = '0;
            rec_cause  = htok_pkg::C_EARLY;
          end
          phase_d  = htok_pkg::PH_METHOD;
          pos_d    = '0;
          tstart_d = '0;
          tlen_d   = '0;
          cand_d   = '0;
          mc_d     = '0;
          hc_d     = '0;
          found_d  = '0;
        end
      end
    end
  end

  assign start_ext = 32'(rec_start);
  assign len_ext   = 32'(rec_len);
  assign hidx_ext  = 32'(rec_hidx);

  always_comb begin
    tok_o.kind   = rec_kind;
    tok_o.start  = (start_ext > 32'(htok_pkg::START_MAX)) ? 11'h7FF : start_ext[10:0];
    tok_o.length = len_ext[11:0];
    tok_o.method = rec_method;
    tok_o.hidx   = hidx_ext[3:0];
    tok_o.cause  = rec_cause;
  end

  assign tok_vld_o = emit;

endmodule

// ===== design/htok_obuf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htok_obuf
// Two-entry result queue that decouples the parser from output stalls.
// ----------------------------------------------------------------------------
module htok_obuf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  htok_pkg::token_t  tok_i,
  output logic              room_o,
  output logic              vld_o,
  input  logic              rdy_i,
  output htok_pkg::token_t  tok_o
);

  htok_pkg::token_t mem_q [2];
  logic             wptr_q, rptr_q;
  logic [1:0]       cnt_q;
  logic             pop;

  assign pop    = vld_o && rdy_i;
  assign vld_o  = (cnt_q != 2'd0);
  assign room_o = (cnt_q != 2'd2);
  assign tok_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= tok_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wptr_q <= ~wptr_q;
      end
      if (pop) begin
        rptr_q <= ~rptr_q;
      end
      case ({push_i, pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule
